// ----- hdl/can_rx_message_table_macros.svh -----
// Assertion macros for the CAN receive message table.
// Used by can_rx_message_table; no other dependency.
`ifndef CAN_RX_MESSAGE_TABLE_MACROS_SVH
`define CAN_RX_MESSAGE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define CRMT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("crmt assertion failed");
`define CRMT_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define CRMT_ASSERT(lbl, clk, rst_n, prop)
`define CRMT_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ----- hdl/crmt_pkg.sv -----
// Types and codes for the CAN receive message table.
// No dependencies; used by crmt_cell and can_rx_message_table.
package crmt_pkg;

  localparam int unsigned SLOT_W = 8;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NEW       = 2'd1;
  localparam logic [1:0] ST_CH_RANGE  = 2'd2;
  localparam logic [1:0] ST_IDX_RANGE = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [3:0]        channel;
    logic [28:0]       frame_id;
    logic [3:0]        length_code;
    logic [63:0]       payload;
    logic [SLOT_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
    logic [3:0]        read_channel;
    logic [28:0]       read_id;
    logic [3:0]        read_length;
    logic [63:0]       read_payload;
  } out_t;

  // One stored frame.
  typedef struct packed {
    logic [3:0]  channel;
    logic [28:0] frame_id;
    logic [3:0]  length_code;
    logic [63:0] payload;
  } entry_t;

  // Search key broadcast to every cell during a scan.
  typedef struct packed {
    logic              operation;
    logic [3:0]        channel;
    logic [28:0]       frame_id;
    logic [SLOT_W-1:0] entry_index;
  } key_t;

  // Entry write broadcast at the end of a store scan.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    entry_t            data;
  } wr_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              have_free;
    logic [SLOT_W-1:0] free_slot;
    logic              have_match;
    logic [SLOT_W-1:0] match_slot;
    entry_t            rd;
  } token_t;

endpackage

// ----- hdl/crmt_cell.sv -----
// One table entry plus one stage of the scan chain.
// Depends on crmt_pkg.
module crmt_cell
  import crmt_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  key_t   key_i,
  input  wr_t    wr_i,
  input  token_t token_i,
  output token_t token_o
);

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(CELL_IDX);

  entry_t entry_q;
  token_t token_q, token_d;
  logic   is_free, is_match;

  assign is_free  = (entry_q.channel == 4'd0) && (entry_q.frame_id == 29'd0) &&
                    (entry_q.length_code == 4'd0);
  assign is_match = (entry_q.frame_id == key_i.frame_id) &&
                    (entry_q.channel == key_i.channel);

  always_comb begin
    token_d = token_i;
    // keep the first free and first matching entry seen so far
    if (!token_i.have_free && is_free) begin
      token_d.have_free = 1'b1;
      token_d.free_slot = MyIdx;
    end
    if (!token_i.have_match && is_match) begin
      token_d.have_match = 1'b1;
      token_d.match_slot = MyIdx;
    end
    if (key_i.operation == OP_READ && key_i.entry_index == MyIdx) begin
      token_d.rd = entry_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else if (token_i.valid) begin
      token_q <= token_d;
    end else begin
      token_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (wr_i.en && wr_i.slot == MyIdx) begin
      entry_q <= wr_i.data;
    end
  end

  assign token_o = token_q;

endmodule

// ----- hdl/can_rx_message_table.sv -----
// CAN receive message table: top level with scan control and result register.
// Depends on crmt_pkg, crmt_cell and can_rx_message_table_macros.svh.
//
//  channel  | ports              | handshake
//  ---------+--------------------+---------------------------------------
//  request  | req_i              | transfer when start_i high, busy_o low
//  result   | rsp_o              | one cycle, marked by done_o
//
// In-range stores and reads: a token walks the cell chain, one cell a cycle,
// so the result strobes after the launch, cell and result registers, and busy_o
// is high until then. Out-of-range store channel or read index: result in the
// cycle after the transfer. Reset clears every entry to free. The receiver
// cannot stall; done_o lasts exactly one cycle.
module can_rx_message_table
  import crmt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = 16,
  parameter int unsigned CHANNEL_COUNT = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  in_t  req_i,
  output logic done_o,
  output out_t rsp_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic   state_q, state_d;
  logic   launch_q, launch_d;
  in_t    req_q;
  logic   done_q, done_d;
  out_t   rsp_q, rsp_d;
  logic   accept, ch_bad, idx_bad, fin;
  key_t   key;
  wr_t    wr;
  token_t tok_w [TABLE_DEPTH+1];
  token_t tail;
  logic [SLOT_W-1:0] wr_slot;

  assign accept  = start_i && (state_q == S_IDLE);
  assign ch_bad  = {1'b0, req_i.channel} >= 5'(CHANNEL_COUNT);
  assign idx_bad = req_i.entry_index >= SLOT_W'(TABLE_DEPTH);

  assign key.operation   = req_q.operation;
  assign key.channel     = req_q.channel;
  assign key.frame_id    = req_q.frame_id;
  assign key.entry_index = req_q.entry_index;

  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = launch_q;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    crmt_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key),
      .wr_i   (wr),
      .token_i(tok_w[i]),
      .token_o(tok_w[i+1])
    );
  end

  assign tail = tok_w[TABLE_DEPTH];
  assign fin  = tail.valid;

  always_comb begin
    if (tail.have_match) begin
      wr_slot = tail.match_slot;
    end else if (tail.have_free) begin
      wr_slot = tail.free_slot;
    end else begin
      wr_slot = '0;
    end
    wr.en               = fin && (req_q.operation == OP_STORE);
    wr.slot             = wr_slot;
    wr.data.channel     = req_q.channel;
    wr.data.frame_id    = req_q.frame_id;
    wr.data.length_code = req_q.length_code;
    wr.data.payload     = req_q.payload;
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    done_d   = 1'b0;
    rsp_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_READ && idx_bad) begin
            done_d       = 1'b1;
            rsp_d.status = ST_IDX_RANGE;
          end else if (req_i.operation == OP_STORE && ch_bad) begin
            done_d       = 1'b1;
            rsp_d.status = ST_CH_RANGE;
          end else begin
            launch_d = 1'b1;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (fin) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (req_q.operation == OP_READ) begin
            rsp_d.status       = ST_OK;
            rsp_d.slot         = req_q.entry_index;
            rsp_d.read_channel = tail.rd.channel;
            rsp_d.read_id      = tail.rd.frame_id;
            rsp_d.read_length  = tail.rd.length_code;
            rsp_d.read_payload = tail.rd.payload;
          end else begin
            rsp_d.status     = tail.have_match ? ST_OK : ST_NEW;
            rsp_d.slot       = wr_slot;
            rsp_d.table_full = !tail.have_free;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      done_q   <= done_d;
    end
  end

  // hold the request for the whole scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q == S_SCAN);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`include "can_rx_message_table_macros.svh"

  `CRMT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o)
  `CRMT_ASSERT(a_tail_in_scan, clk_i, rst_ni, fin |-> state_q == S_SCAN)
  `CRMT_ASSERT(a_launch_in_scan, clk_i, rst_ni, launch_q |-> busy_o && !fin)
  `CRMT_ASSERT_MSG(a_accept_answered, clk_i, rst_ni,
    (start_i && !busy_o) |=> (done_o || busy_o), "accepted item dropped")
  `CRMT_ASSERT_MSG(a_ch_range_clean, clk_i, rst_ni,
    (done_o && rsp_o.status == ST_CH_RANGE) |-> (rsp_o.slot == '0 && !rsp_o.table_full),
    "channel range result carries slot data")

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for can_rx_message_table: directed table walk, then random traffic.
// Depends on crmt_pkg and the can_rx_message_table RTL; results are checked
// against an in-bench model of the frame table or against hand-written results.
module tb_top;
  import crmt_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 16;
  localparam int unsigned CHANNEL_COUNT = 2;
  localparam int unsigned RANDOM_ITEMS  = 1950;
  localparam int unsigned DRAIN_CYCLES  = TABLE_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam logic [28:0] ID_MAX        = '1;

  typedef struct packed {
    in_t        req;
    logic [4:0] reps;    // repeat count; frame_id advances by one per repeat
    logic       typed;   // want holds a hand-written result
    out_t       want;
  } step_t;

  logic clk;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  req_i;
  logic done_o;
  out_t rsp_o;

  entry_t      frame_table [TABLE_DEPTH];
  out_t        pending_results [$];
  step_t       plan [$];
  logic [28:0] id_pool [16];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned burst_left;
  int unsigned new_entries;
  int unsigned updates;
  int unsigned full_stores;
  int unsigned range_errors;

  can_rx_message_table #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic in_t store_req(logic [3:0] ch, logic [28:0] id, logic [3:0] len,
                                    logic [63:0] pay);
    in_t r;
    r = '0;
    r.operation   = OP_STORE;
    r.channel     = ch;
    r.frame_id    = id;
    r.length_code = len;
    r.payload     = pay;
    return r;
  endfunction

  function automatic in_t read_req(logic [7:0] idx);
    in_t r;
    r = '0;
    r.operation   = OP_READ;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic out_t make_result(logic [1:0] st, logic [7:0] slot, logic full,
                                       entry_t e);
    out_t o;
    o = '0;
    o.status       = st;
    o.slot         = slot;
    o.table_full   = full;
    o.read_channel = e.channel;
    o.read_id      = e.frame_id;
    o.read_length  = e.length_code;
    o.read_payload = e.payload;
    return o;
  endfunction

  // Apply one request to the table copy and return the result it must produce.
  function automatic out_t file_frame(in_t r);
    int     free_at;
    int     match_at;
    int     i;
    int     slot;
    entry_t e;
    out_t   o;
    o = '0;
    if (r.operation == OP_READ) begin
      if (r.entry_index >= TABLE_DEPTH) begin
        o.status = ST_IDX_RANGE;
      end else begin
        o = make_result(ST_OK, r.entry_index, 1'b0, frame_table[r.entry_index]);
      end
    end else if (r.channel >= CHANNEL_COUNT) begin
      o.status = ST_CH_RANGE;
    end else begin
      free_at  = -1;
      match_at = -1;
      for (i = 0; i < TABLE_DEPTH; i++) begin
        if (free_at < 0 && frame_table[i].channel == 0 && frame_table[i].frame_id == 0 &&
            frame_table[i].length_code == 0) begin
          free_at = i;
        end
        if (match_at < 0 && frame_table[i].frame_id == r.frame_id &&
            frame_table[i].channel == r.channel) begin
          match_at = i;
        end
      end
      slot = (match_at >= 0) ? match_at : (free_at >= 0) ? free_at : 0;
      e.channel     = r.channel;
      e.frame_id    = r.frame_id;
      e.length_code = r.length_code;
      e.payload     = r.payload;
      frame_table[slot] = e;
      o.status     = (match_at >= 0) ? ST_OK : ST_NEW;
      o.slot       = slot[7:0];
      o.table_full = (free_at < 0);
    end
    return o;
  endfunction

  // Mostly in-range stores over a small key pool so updates and a full table are common.
  function automatic in_t random_request();
    in_t         r;
    int unsigned pick;
    r = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      r.operation   = OP_READ;
      r.entry_index = ($urandom_range(0, 9) == 0) ? $urandom_range(TABLE_DEPTH, 255)
                                                  : $urandom_range(0, TABLE_DEPTH - 1);
    end else if (pick < 34) begin
      r.operation = OP_STORE;
      r.channel   = $urandom_range(CHANNEL_COUNT, 15);
    end else if (pick < 42) begin
      // all-zero key frees the entry it lands in
      r.operation   = OP_STORE;
      r.channel     = '0;
      r.frame_id    = '0;
      r.length_code = '0;
    end else begin
      r.operation = OP_STORE;
      r.channel   = $urandom_range(0, CHANNEL_COUNT - 1);
      if ($urandom_range(0, 6) != 0) r.frame_id = id_pool[$urandom_range(0, 15)];
    end
    return r;
  endfunction

  // Present one request from the falling edge; hold it until the transfer.
  task automatic send(in_t r, logic typed, out_t want);
    out_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk);
    while (busy_o !== 1'b0) @(posedge clk);
    predicted = file_frame(r);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** can_rx_message_table: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t want;
    logic bad;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("unexpected result %p", rsp_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        bad = (rsp_o.status !== want.status) || (rsp_o.slot !== want.slot) ||
              (rsp_o.table_full !== want.table_full) ||
              (rsp_o.read_channel !== want.read_channel) ||
              (rsp_o.read_id !== want.read_id) ||
              (rsp_o.read_length !== want.read_length) ||
              (rsp_o.read_payload !== want.read_payload);
        if (bad) begin
          if (mismatches < 10) begin
            $display("mismatch on result %0d", results_checked);
            $display("  expected %p", want);
            $display("  actual   %p", rsp_o);
          end
          mismatches++;
        end
        case (want.status)
          ST_NEW:       new_entries++;
          ST_OK:        updates++;
          default:      range_errors++;
        endcase
        if (want.table_full) full_stores++;
      end
    end
  end

  initial begin
    in_t         r;
    int unsigned i;
    int unsigned n;
    entry_t      e;

    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    for (i = 0; i < TABLE_DEPTH; i++) frame_table[i] = '0;
    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    for (i = 2; i < 16; i++) id_pool[i] = $urandom;

    e = {4'd1, ID_MAX, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF};
    // hold the table at reset, then walk the directed plan
    plan.push_back({read_req(8'd0), 5'd1, 1'b1, make_result(ST_OK, 8'd0, 1'b0, '0)});
    plan.push_back({read_req(8'd16), 5'd1, 1'b1, make_result(ST_IDX_RANGE, 8'd0, 1'b0, '0)});
    plan.push_back({in_t'('1), 5'd1, 1'b1, make_result(ST_IDX_RANGE, 8'd0, 1'b0, '0)});
    plan.push_back({store_req(4'd2, 29'h1234, 4'd8, 64'h0102_0304_0506_0708), 5'd1, 1'b1,
                    make_result(ST_CH_RANGE, 8'd0, 1'b0, '0)});
    r = '1;
    r.operation = OP_STORE;
    plan.push_back({r, 5'd1, 1'b1, make_result(ST_CH_RANGE, 8'd0, 1'b0, '0)});
    plan.push_back({store_req(e.channel, e.frame_id, e.length_code, e.payload), 5'd1, 1'b1,
                    make_result(ST_NEW, 8'd0, 1'b0, '0)});
    plan.push_back({read_req(8'd0), 5'd1, 1'b1, make_result(ST_OK, 8'd0, 1'b0, e)});
    // key 0/0 matches a free entry; an all-zero frame frees it again
    plan.push_back({store_req(4'd0, 29'd0, 4'd5, 64'h0123_4567_89AB_CDEF), 5'd1, 1'b0, out_t'('0)});
    plan.push_back({store_req(4'd0, 29'd0, 4'd0, 64'hA5A5_5A5A_A5A5_5A5A), 5'd1, 1'b0, out_t'('0)});
    plan.push_back({store_req(4'd1, 29'h0AAA_AAAA, 4'd8, 64'h0), 5'd1, 1'b0, out_t'('0)});
    plan.push_back({store_req(4'd1, ID_MAX, 4'd3, 64'h0), 5'd1, 1'b0, out_t'('0)});
    plan.push_back({store_req(4'd0, 29'h100, 4'd8, 64'hDEAD_BEEF_0BAD_F00D), 5'd14, 1'b0,
                    out_t'('0)});
    plan.push_back({store_req(4'd1, 29'h1555_5555, 4'd2, 64'h5555_AAAA_5555_AAAA), 5'd1, 1'b1,
                    make_result(ST_NEW, 8'd0, 1'b1, '0)});
    plan.push_back({read_req(8'd0), 5'd1, 1'b0, out_t'('0)});
    plan.push_back({read_req(8'd15), 5'd1, 1'b0, out_t'('0)});
    plan.push_back({store_req(4'd0, 29'd0, 4'd0, 64'h7E7E_7E7E_7E7E_7E7E), 5'd1, 1'b0,
                    out_t'('0)});
    plan.push_back({store_req(4'd1, 29'd5, 4'd1, 64'h0000_0000_0000_00FF), 5'd1, 1'b0,
                    out_t'('0)});

    repeat (12) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    for (i = 0; i < plan.size(); i++) begin
      for (n = 0; n < plan[i].reps; n++) begin
        r = plan[i].req;
        r.frame_id = r.frame_id + n;
        send(r, plan[i].typed, plan[i].want);
      end
    end

    for (i = 0; i < RANDOM_ITEMS; i++) send(random_request(), 1'b0, out_t'('0));
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d mismatches", requests_sent,
             results_checked, mismatches);
    $display("new entries %0d, updates/reads %0d, full-table stores %0d, range errors %0d",
             new_entries, updates, full_stores, range_errors);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** can_rx_message_table: PASSED **");
    end else begin
      $display("** can_rx_message_table: FAILED **");
    end
    $finish;
  end

endmodule
